// ===== hdl/button_debounce_click_hold_core_macros.svh =====
// Assertion macros shared by the checker of the button debounce core.
// Depends on nothing; the including module supplies clk and rst.
`ifndef BUTTON_DEBOUNCE_CLICK_HOLD_CORE_MACROS_SVH
`define BUTTON_DEBOUNCE_CLICK_HOLD_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define BDCH_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define BDCH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/bdch_pkg.sv =====
// Shared types, command codes and register constants of the button debounce core.
// No dependencies; the design and test modules refer to it by scoped names.
package bdch_pkg;

  localparam int unsigned CountW = 16;
  localparam int unsigned HoldW  = CountW + 1;
  localparam int unsigned CfgIndexW = 2;

  typedef enum logic [2:0] {
    CMD_TICK          = 3'd0,
    CMD_TAKE_PRESSED  = 3'd1,
    CMD_TAKE_RELEASED = 3'd2,
    CMD_TAKE_CLICK    = 3'd3,
    CMD_TAKE_HOLD     = 3'd4
  } cmd_e;

  localparam logic [CfgIndexW-1:0] REG_DEBOUNCE_LIMIT = 2'd0;
  localparam logic [CfgIndexW-1:0] REG_HOLD_LIMIT     = 2'd1;
  localparam logic [CfgIndexW-1:0] REG_PRESSED_LEVEL  = 2'd2;

  localparam logic [CountW-1:0] DEBOUNCE_LIMIT_RESET = 16'd10;
  localparam logic [CountW-1:0] HOLD_LIMIT_RESET     = 16'd1000;
  localparam logic              PRESSED_LEVEL_RESET  = 1'b0;

  typedef struct packed {
    logic [2:0] command;
    logic       pin_level;
  } in_item_t;

  typedef struct packed {
    logic is_pressed;
    logic is_holding;
    logic event_taken;
    logic beep_pulse;
    logic click_pulse;
    logic hold_pulse;
  } out_item_t;

  typedef struct packed {
    logic [CountW-1:0] debounce_limit;
    logic [CountW-1:0] hold_limit;
    logic              pressed_level;
  } cfg_t;

  typedef struct packed {
    logic [CountW-1:0] debounce_count;
    logic [HoldW-1:0]  hold_count;
    logic              debounced_state;
    logic              pressed_event;
    logic              released_event;
    logic              click_event;
    logic              hold_event;
  } state_t;

endpackage

// ===== hdl/button_debounce_click_hold_core.sv =====
// Button debouncer with click and long-hold detection: top level.
// Depends on bdch_pkg, bdch_cfg and bdch_step.
//
// Usage: each input item is a command. A tick carries one sampled pin level;
// the debounced state flips after the level has disagreed with it on more
// than debounce_limit ticks in a row. While pressed, a hold counter runs and
// a hold pulse fires when it reaches hold_limit; a release before that fires
// a click pulse. Commands 1 to 4 take and clear the latched pressed, released,
// click and hold events. Every item yields exactly one result item, held in a
// single output register and presented in the cycle after the item is accepted.
// The block takes one item per cycle: all state updates in the same cycle the
// item is accepted, through one short pass of compare and increment logic, so
// throughput is bounded only by the output register. in_ready is high when
// that register is empty or is being drained in the same cycle. Configuration
// writes take effect on the next edge and have no handshake; write them only
// while no item is in flight.
module button_debounce_click_hold_core (
  input  logic                           clk,
  input  logic                           rst,
  // configuration write port
  input  logic                           cfg_we,
  input  logic [bdch_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [bdch_pkg::CountW-1:0]    cfg_data,
  // command channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  bdch_pkg::in_item_t             in_item,
  // result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output bdch_pkg::out_item_t            out_item
);

  bdch_pkg::cfg_t      cfg;
  bdch_pkg::state_t    state;
  bdch_pkg::state_t    state_next;
  bdch_pkg::out_item_t result;
  logic                in_accept;

  bdch_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bdch_step u_step (
    .cfg        (cfg),
    .state      (state),
    .item       (in_item),
    .state_next (state_next),
    .result     (result)
  );

  // Accept while the output register is empty or draining this cycle.
  assign in_ready  = !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;

  // Advance the debounce/hold state only on an accepted item.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (in_accept) begin
      state <= state_next;
    end
  end

  // Output register: load on accept, drop when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Hold the result payload until the next accepted item.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_item <= result;
    end
  end

endmodule

// ===== hdl/bdch_cfg.sv =====
// Configuration register file: debounce limit, hold limit, pressed level.
// Depends on bdch_pkg.
module bdch_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [bdch_pkg::CfgIndexW-1:0]     cfg_index,
  input  logic [bdch_pkg::CountW-1:0]        cfg_data,
  output bdch_pkg::cfg_t                     cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_limit <= bdch_pkg::DEBOUNCE_LIMIT_RESET;
      cfg.hold_limit     <= bdch_pkg::HOLD_LIMIT_RESET;
      cfg.pressed_level  <= bdch_pkg::PRESSED_LEVEL_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        bdch_pkg::REG_DEBOUNCE_LIMIT: cfg.debounce_limit <= cfg_data;
        bdch_pkg::REG_HOLD_LIMIT:     cfg.hold_limit     <= cfg_data;
        bdch_pkg::REG_PRESSED_LEVEL:  cfg.pressed_level  <= cfg_data[0];
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

endmodule

// ===== hdl/bdch_step.sv =====
// Next-state and result logic for one item of the button debounce core.
// Purely combinational; depends on bdch_pkg.
module bdch_step (
  input  bdch_pkg::cfg_t      cfg,
  input  bdch_pkg::state_t    state,
  input  bdch_pkg::in_item_t  item,
  output bdch_pkg::state_t    state_next,
  output bdch_pkg::out_item_t result
);

  logic                       active;
  logic                       db_below;
  logic                       hold_inc;
  logic                       hold_fire;
  logic                       hold_early;
  logic [bdch_pkg::HoldW-1:0] hold_limit_x;
  logic [bdch_pkg::HoldW-1:0] hold_p1;
  logic [bdch_pkg::HoldW-1:0] hold_p2;

  always_comb begin
    hold_limit_x = {1'b0, cfg.hold_limit};
    active       = (item.pin_level == cfg.pressed_level);
    db_below     = (state.debounce_count < cfg.debounce_limit);
    hold_p1      = state.hold_count + bdch_pkg::HoldW'(1);
    hold_p2      = state.hold_count + bdch_pkg::HoldW'(2);
    hold_inc     = (state.hold_count <= hold_limit_x);
    hold_fire    = hold_inc && (hold_p1 == hold_limit_x);
    hold_early   = (state.hold_count < hold_limit_x);

    state_next         = state;
    result.event_taken = 1'b0;
    result.click_pulse = 1'b0;
    result.hold_pulse  = 1'b0;

    case (item.command)
      bdch_pkg::CMD_TICK: begin
        if (active) begin
          if (!state.debounced_state) begin
            if (db_below) begin
              state_next.debounce_count = state.debounce_count + bdch_pkg::CountW'(1);
            end else begin
              state_next.debounce_count  = '0;
              state_next.debounced_state = 1'b1;
              state_next.pressed_event   = 1'b1;
              state_next.released_event  = 1'b0;
            end
          end else begin
            state_next.debounce_count = '0;
            // Saturate one past the limit; the step onto the limit fires a hold.
            if (hold_fire) begin
              state_next.hold_count = hold_p2;
              state_next.hold_event = 1'b1;
              result.hold_pulse     = 1'b1;
            end else if (hold_inc) begin
              state_next.hold_count = hold_p1;
            end
          end
        end else begin
          if (state.debounced_state) begin
            if (db_below) begin
              state_next.debounce_count = state.debounce_count + bdch_pkg::CountW'(1);
            end else begin
              state_next.debounce_count  = '0;
              state_next.debounced_state = 1'b0;
              state_next.released_event  = 1'b1;
              state_next.pressed_event   = 1'b0;
              state_next.hold_count      = '0;
              if (hold_early) begin
                state_next.click_event = 1'b1;
                result.click_pulse     = 1'b1;
              end
            end
          end else begin
            state_next.debounce_count = '0;
            state_next.hold_event     = 1'b0;
          end
        end
      end
      bdch_pkg::CMD_TAKE_PRESSED: begin
        if (state.pressed_event) begin
          state_next.pressed_event  = 1'b0;
          state_next.released_event = 1'b0;
          result.event_taken        = 1'b1;
        end
      end
      bdch_pkg::CMD_TAKE_RELEASED: begin
        if (state.released_event) begin
          state_next.pressed_event  = 1'b0;
          state_next.released_event = 1'b0;
          result.event_taken        = 1'b1;
        end
      end
      bdch_pkg::CMD_TAKE_CLICK: begin
        if (state.click_event) begin
          state_next.click_event    = 1'b0;
          state_next.released_event = 1'b0;
          state_next.pressed_event  = 1'b0;
          result.click_pulse        = 1'b1;
          result.event_taken        = 1'b1;
        end
      end
      bdch_pkg::CMD_TAKE_HOLD: begin
        if (state.hold_event) begin
          state_next.pressed_event = 1'b0;
          state_next.hold_event    = 1'b0;
          result.hold_pulse        = 1'b1;
          result.event_taken       = 1'b1;
        end
      end
      default: ;  // unused command: change nothing
    endcase

    result.beep_pulse = result.click_pulse | result.hold_pulse;
    result.is_pressed = state_next.debounced_state;
    result.is_holding = (state_next.hold_count >= hold_limit_x);
  end

endmodule

// ===== hdl/bdch_checker.sv =====
// Port-level checker for the button debounce core, bound to the top level.
// Depends on bdch_pkg and button_debounce_click_hold_core_macros.svh.
`include "button_debounce_click_hold_core_macros.svh"

module bdch_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input bdch_pkg::in_item_t  in_item,
  input logic                out_valid,
  input logic                out_ready,
  input bdch_pkg::out_item_t out_item
);

  logic in_take;
  logic out_stall;
  logic unused_cmd;
  logic pulses_ok;

  assign in_take    = in_valid && in_ready;
  assign out_stall  = out_valid && !out_ready;
  assign unused_cmd = (in_item.command > bdch_pkg::CMD_TAKE_HOLD);
  assign pulses_ok  = (out_item.beep_pulse == (out_item.click_pulse || out_item.hold_pulse))
                      && !(out_item.click_pulse && out_item.hold_pulse);

  // Every accepted item leaves a result in the output register.
  `BDCH_ASSERT_NEXT(a_accept_gives_result, in_take, out_valid, "accepted item gave no result")

  // Beep fires exactly when a click or hold notification fires, never both.
  `BDCH_ASSERT_NOW(a_pulse_consistent, out_valid, pulses_ok, "inconsistent pulses")

  // Unused commands take nothing and fire nothing.
  `BDCH_ASSERT_NEXT(a_unused_cmd_quiet, in_take && unused_cmd, !out_item.event_taken && !out_item.beep_pulse, "unused command had an effect")

  // A stalled result stays put.
  `BDCH_ASSERT_NEXT(a_result_holds, out_stall, out_valid && $stable(out_item), "stalled result changed")

endmodule

bind button_debounce_click_hold_core bdch_checker u_bdch_checker (.*);

// ===== dv/button_debounce_click_hold_core_test.sv =====
// Self-checking testbench for the button debounce core with click and long-hold detection.
// Depends on bdch_pkg and button_debounce_click_hold_core; a scoreboard class predicts
// every result item while plain tasks drive commands and configuration writes.
module button_debounce_click_hold_core_test;

  // Commands the block must ignore: no state change, no event, no pulse.
  localparam logic [2:0] CMD_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] CMD_UNUSED_LAST  = 3'd7;

  // Give up well past the slowest legal run (about 600 items, each worst-case
  // sender gap plus a sparse receiver).
  localparam int unsigned CYCLE_LIMIT = 200000;

  // Cap run lengths so the huge limits do not stretch a phase.
  localparam int unsigned MAX_RUN = 40;

  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_RANDOM,
    READY_SPARSE
  } ready_mode_e;

  // Predict the result of each accepted item and hold the expectations in order.
  class click_hold_scoreboard;
    logic [bdch_pkg::CountW-1:0] debounce_limit;
    logic [bdch_pkg::CountW-1:0] hold_limit;
    logic                        pressed_level;
    logic [bdch_pkg::CountW-1:0] debounce_count;
    logic [bdch_pkg::HoldW-1:0]  hold_count;
    logic                        pressed_state;
    logic                        pressed_latched;
    logic                        released_latched;
    logic                        click_latched;
    logic                        hold_latched;
    bdch_pkg::out_item_t         expected_results[$];
    int unsigned                 mismatches;

    function new();
      debounce_limit   = bdch_pkg::DEBOUNCE_LIMIT_RESET;
      hold_limit       = bdch_pkg::HOLD_LIMIT_RESET;
      pressed_level    = bdch_pkg::PRESSED_LEVEL_RESET;
      debounce_count   = '0;
      hold_count       = '0;
      pressed_state    = 1'b0;
      pressed_latched  = 1'b0;
      released_latched = 1'b0;
      click_latched    = 1'b0;
      hold_latched     = 1'b0;
      mismatches       = 0;
    endfunction

    function void write_register(logic [bdch_pkg::CfgIndexW-1:0] index,
                                 logic [bdch_pkg::CountW-1:0] value);
      case (index)
        bdch_pkg::REG_DEBOUNCE_LIMIT: debounce_limit = value;
        bdch_pkg::REG_HOLD_LIMIT:     hold_limit = value;
        bdch_pkg::REG_PRESSED_LEVEL:  pressed_level = value[0];
        default: ;
      endcase
    endfunction

    // Advance the debouncer by one accepted item and queue the result it gives.
    function void note_command(bdch_pkg::in_item_t item);
      bdch_pkg::out_item_t res;
      logic                active;
      res = '0;
      case (item.command)
        bdch_pkg::CMD_TICK: begin
          active = (item.pin_level == pressed_level);
          if (active && !pressed_state) begin
            if (debounce_count < debounce_limit) begin
              debounce_count = debounce_count + 1'b1;
            end else begin
              debounce_count   = '0;
              pressed_state    = 1'b1;
              pressed_latched  = 1'b1;
              released_latched = 1'b0;
            end
          end else if (active) begin
            // Hold counter saturates one above the limit; the pulse fires once.
            debounce_count = '0;
            if (hold_count <= {1'b0, hold_limit}) hold_count = hold_count + 1'b1;
            if (hold_count == {1'b0, hold_limit}) begin
              hold_count       = hold_count + 1'b1;
              res.beep_pulse   = 1'b1;
              res.hold_pulse   = 1'b1;
              hold_latched     = 1'b1;
            end
          end else if (pressed_state) begin
            if (debounce_count < debounce_limit) begin
              debounce_count = debounce_count + 1'b1;
            end else begin
              debounce_count   = '0;
              pressed_state    = 1'b0;
              released_latched = 1'b1;
              pressed_latched  = 1'b0;
              // Released before the hold limit: a click.
              if (hold_count < {1'b0, hold_limit}) begin
                res.beep_pulse  = 1'b1;
                res.click_pulse = 1'b1;
                click_latched   = 1'b1;
              end
              hold_count = '0;
            end
          end else begin
            // Idle released tick drops any stale hold event.
            debounce_count = '0;
            hold_latched   = 1'b0;
          end
        end
        bdch_pkg::CMD_TAKE_PRESSED: begin
          if (pressed_latched) begin
            pressed_latched  = 1'b0;
            released_latched = 1'b0;
            res.event_taken  = 1'b1;
          end
        end
        bdch_pkg::CMD_TAKE_RELEASED: begin
          if (released_latched) begin
            pressed_latched  = 1'b0;
            released_latched = 1'b0;
            res.event_taken  = 1'b1;
          end
        end
        bdch_pkg::CMD_TAKE_CLICK: begin
          if (click_latched) begin
            click_latched    = 1'b0;
            released_latched = 1'b0;
            pressed_latched  = 1'b0;
            res.beep_pulse   = 1'b1;
            res.click_pulse  = 1'b1;
            res.event_taken  = 1'b1;
          end
        end
        bdch_pkg::CMD_TAKE_HOLD: begin
          if (hold_latched) begin
            pressed_latched = 1'b0;
            hold_latched    = 1'b0;
            res.beep_pulse  = 1'b1;
            res.hold_pulse  = 1'b1;
            res.event_taken = 1'b1;
          end
        end
        default: ;
      endcase
      res.is_pressed = pressed_state;
      res.is_holding = (hold_count >= {1'b0, hold_limit});
      expected_results.push_back(res);
    endfunction

    function void compare_bit(string field, logic want, logic got);
      if (got !== want) begin
        $error("%s: expected %0b, got %0b", field, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(bdch_pkg::out_item_t got);
      bdch_pkg::out_item_t want;
      if (expected_results.size() == 0) begin
        $error("result item arrived with no expectation pending");
        mismatches++;
        return;
      end
      want = expected_results.pop_front();
      compare_bit("is_pressed", want.is_pressed, got.is_pressed);
      compare_bit("is_holding", want.is_holding, got.is_holding);
      compare_bit("event_taken", want.event_taken, got.event_taken);
      compare_bit("beep_pulse", want.beep_pulse, got.beep_pulse);
      compare_bit("click_pulse", want.click_pulse, got.click_pulse);
      compare_bit("hold_pulse", want.hold_pulse, got.hold_pulse);
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_we = 1'b0;
  logic [bdch_pkg::CfgIndexW-1:0] cfg_index = '0;
  logic [bdch_pkg::CountW-1:0]    cfg_data = '0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  bdch_pkg::in_item_t             in_item = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  bdch_pkg::out_item_t            out_item;

  click_hold_scoreboard sb;

  // Sender burst bookkeeping and the configuration the stimulus is aimed at.
  int unsigned burst_left = 0;
  int unsigned cur_debounce = bdch_pkg::DEBOUNCE_LIMIT_RESET;
  int unsigned cur_hold = bdch_pkg::HOLD_LIMIT_RESET;
  logic        cur_level = bdch_pkg::PRESSED_LEVEL_RESET;

  // Receiver stall pattern and run watchdog.
  ready_mode_e ready_mode = READY_ALWAYS;
  int unsigned stall_count = 0;
  int unsigned cycle_count = 0;

  // Random phases: small limits mostly, plus the extremes of each register.
  int unsigned phase_debounce [7] = '{1, 0, 3, 65535, 0, 2, 1};
  int unsigned phase_hold     [7] = '{6, 3, 12, 65535, 65535, 0, 2};
  logic        phase_level    [7] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
  int unsigned phase_items    [7] = '{80, 70, 80, 20, 40, 60, 70};

  button_debounce_click_hold_core u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  always #5 clk = ~clk;

  // Sample both handshakes at the edge; drivers only use nonblocking updates.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_command(in_item);
      if (out_valid && out_ready) sb.check_result(out_item);
    end
  end

  // Receiver: switch among always ready, random stalls and sparse ready.
  always @(posedge clk) begin
    stall_count <= stall_count + 1;
    if (stall_count % 64 == 0) ready_mode <= ready_mode_e'($urandom_range(0, 2));
    case (ready_mode)
      READY_ALWAYS: out_ready <= 1'b1;
      READY_RANDOM: out_ready <= ($urandom_range(0, 3) != 0);
      default:      out_ready <= (stall_count % 8 == 0);
    endcase
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("button_debounce_click_hold_core_test failed");
      $finish;
    end
  end

  // Present one item and hold it until accepted; open a new burst, sometimes after a gap.
  task automatic send_command(logic [2:0] cmd, logic level);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_item  <= '{command: cmd, pin_level: level};
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_ticks(logic level, int unsigned count);
    repeat (count) send_command(bdch_pkg::CMD_TICK, level);
  endtask

  // Drop valid and wait until every expected result has come back.
  task automatic wait_until_drained();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (sb.expected_results.size() != 0 || out_valid);
  endtask

  // Write all three registers while the block is idle; state carries over.
  task automatic configure(int unsigned debounce, int unsigned hold, logic level);
    wait_until_drained();
    repeat (2) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= bdch_pkg::REG_DEBOUNCE_LIMIT;
    cfg_data  <= bdch_pkg::CountW'(debounce);
    @(posedge clk);
    cfg_index <= bdch_pkg::REG_HOLD_LIMIT;
    cfg_data  <= bdch_pkg::CountW'(hold);
    @(posedge clk);
    cfg_index <= bdch_pkg::REG_PRESSED_LEVEL;
    cfg_data  <= bdch_pkg::CountW'(level);
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_register(bdch_pkg::REG_DEBOUNCE_LIMIT, bdch_pkg::CountW'(debounce));
    sb.write_register(bdch_pkg::REG_HOLD_LIMIT, bdch_pkg::CountW'(hold));
    sb.write_register(bdch_pkg::REG_PRESSED_LEVEL, bdch_pkg::CountW'(level));
    cur_debounce = debounce;
    cur_hold     = hold;
    cur_level    = level;
  endtask

  // Mostly full press/release cycles with random lengths, glitches and takes;
  // the rest is stray ticks, stray takes and ignored commands.
  task automatic run_random_phase(int unsigned item_goal);
    int unsigned done_items;
    int unsigned choice;
    int unsigned run_len;
    done_items = 0;
    while (done_items < item_goal) begin
      choice = $urandom_range(0, 99);
      if (choice < 55) begin
        // Bounce before the press.
        if ($urandom_range(0, 2) == 0) begin
          repeat ($urandom_range(1, 4)) begin
            send_command(bdch_pkg::CMD_TICK, 1'($urandom_range(0, 1)));
            done_items++;
          end
        end
        // Press long enough to flip unless MAX_RUN cuts it, sometimes long enough to reach the hold.
        run_len = cur_debounce + 1 +
                  (($urandom_range(0, 2) == 0) ? cur_hold + $urandom_range(0, 2)
                                               : $urandom_range(0, cur_hold));
        if (run_len > MAX_RUN) run_len = MAX_RUN;
        repeat (run_len) begin
          send_command(bdch_pkg::CMD_TICK,
                       ($urandom_range(0, 15) == 0) ? !cur_level : cur_level);
          done_items++;
        end
        run_len = cur_debounce + 1 + $urandom_range(0, 2);
        if (run_len > MAX_RUN) run_len = MAX_RUN;
        send_ticks(!cur_level, run_len);
        done_items += run_len;
        for (int c = bdch_pkg::CMD_TAKE_PRESSED; c <= bdch_pkg::CMD_TAKE_HOLD; c++) begin
          if ($urandom_range(0, 1) == 1) begin
            send_command(3'(c), 1'($urandom_range(0, 1)));
            done_items++;
          end
        end
      end else if (choice < 75) begin
        send_command(3'($urandom_range(bdch_pkg::CMD_TAKE_PRESSED, bdch_pkg::CMD_TAKE_HOLD)),
                     1'($urandom_range(0, 1)));
        done_items++;
      end else if (choice < 95) begin
        send_command(bdch_pkg::CMD_TICK, 1'($urandom_range(0, 1)));
        done_items++;
      end else begin
        send_command(3'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST)),
                     1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Reset configuration: ignored commands, a take with nothing latched,
    // an inactive tick (pressed level is low).
    for (int c = CMD_UNUSED_FIRST; c <= CMD_UNUSED_LAST; c++) send_command(3'(c), 1'(c));
    send_command(bdch_pkg::CMD_TAKE_HOLD, 1'b1);
    send_ticks(1'b1, 1);

    // Active-high button: flip on the third tick, hold fires five ticks later.
    configure(2, 5, 1'b1);
    send_ticks(1'b1, 8);
    send_command(bdch_pkg::CMD_TAKE_PRESSED, 1'b0);
    send_command(bdch_pkg::CMD_TAKE_HOLD, 1'b1);

    // Lower the hold limit below the running counter: it stops advancing and
    // the release gives no click. Then a short press that does click.
    configure(2, 3, 1'b1);
    send_ticks(1'b1, 1);
    send_ticks(1'b0, 3);
    send_ticks(1'b1, 3);
    send_ticks(1'b0, 3);
    send_command(bdch_pkg::CMD_TAKE_CLICK, 1'b0);

    // Zero debounce and zero hold limit: instant flips, never a click or hold.
    configure(0, 0, 1'b0);
    send_ticks(1'b0, 2);
    send_ticks(1'b1, 1);

    foreach (phase_items[p]) begin
      configure(phase_debounce[p], phase_hold[p], phase_level[p]);
      run_random_phase(phase_items[p]);
    end
    configure($urandom_range(0, 4), $urandom_range(0, 15), 1'($urandom_range(0, 1)));
    run_random_phase(80);

    wait_until_drained();
    repeat (4) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_results.size() == 0) begin
      $display("button_debounce_click_hold_core_test passed");
    end else begin
      $display("button_debounce_click_hold_core_test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/bdch_pkg.sv
hdl/bdch_cfg.sv
hdl/bdch_step.sv
hdl/button_debounce_click_hold_core.sv
hdl/bdch_checker.sv
dv/button_debounce_click_hold_core_test.sv
